// ===== src/tts_pkg.sv =====
// Shared types and constants for the transition table sampler.
`timescale 1ns / 1ps

package tts_pkg;

  // Default sizing
  localparam int MAX_RATINGS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // Fixed field widths on the stream and configuration ports
  localparam int IDX_W   = 4;
  localparam int PROB_W  = 18;
  localparam int DRAW_W  = 16;
  localparam int CFG_W   = 5;
  localparam int STAT_W  = 2;

  // Reset value of the rating count before clamping to the table size
  localparam int RESET_COUNT = 16;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_INDEX = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_REDEF = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRCHK,
    ST_WALK,
    ST_RESP
  } state_e;

endpackage

// ===== src/transition_table_sampler.sv =====
// Transition table sampler: probability table in block RAM, write checks, inverse CDF walk.
`timescale 1ns / 1ps

//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+---------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tuser: cmd; tdata: row, col,
//            |           |                             |   prob_value, uniform_draw
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata: next_rating, status
//  cfg       | in        | cfg_wr_en_i                 | cfg_wr_data_i: rating_count
//
//  A write is accepted with a table read, then checked and written back, then its result is given.
//  A sample walks the columns of its row (1..rating_count of them, none for a row
//  beyond the count), one table read per cycle through the single read port.
//  After reset a clearing pass marks all MAX_RATINGS*MAX_RATINGS entries undefined,
//  one per cycle; no word is accepted meanwhile.
//  A result waits in the output register while m_axis_tready is low; the next word
//  is accepted and worked on, and it only waits if its own result is due.

module transition_table_sampler
  import tts_pkg::*;
#(
  parameter int MAX_RATINGS = MAX_RATINGS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_wr_en_i,
  input  logic [CFG_W-1:0] cfg_wr_data_i,   // rating_count
  // input words
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [0:0]       s_axis_tuser,    // [0] cmd
  input  logic [47:0]      s_axis_tdata,    // [3:0] row_index, [7:4] col_index,
                                            // [25:8] prob_value, [41:26] uniform_draw
  // result words
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata     // [3:0] next_rating, [5:4] status
);

  localparam int DEPTH = MAX_RATINGS * MAX_RATINGS;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = FRAC_BITS + 1;                       // stored value width
  localparam int MW    = VW + 1;                              // defined mark + value
  localparam int SW    = FRAC_BITS + 1 + $clog2(MAX_RATINGS); // running sum width
  localparam int CW    = $clog2(MAX_RATINGS + 1);             // rating count width
  localparam int XW    = (CW > IDX_W) ? CW : IDX_W;           // index compare width
  localparam int VCW   = (FRAC_BITS + 2 > PROB_W) ? FRAC_BITS + 2 : PROB_W;
  localparam int SH_L  = (FRAC_BITS >= DRAW_W) ? FRAC_BITS - DRAW_W : 0;
  localparam int SH_R  = (FRAC_BITS < DRAW_W) ? DRAW_W - FRAC_BITS : 0;
  localparam int TW    = DRAW_W + SH_L;
  localparam int RST_CNT = (RESET_COUNT > MAX_RATINGS) ? MAX_RATINGS : RESET_COUNT;
  localparam logic [VCW-1:0] ONE_VAL = VCW'(1) << FRAC_BITS;

  function automatic logic [AW-1:0] ent_addr(input logic [IDX_W-1:0] r, input int c);
    int a;
    a = int'(r) * MAX_RATINGS + c;
    return AW'(a);
  endfunction

  // Input word fields
  logic                     s_cmd;
  logic [IDX_W-1:0]         s_row;
  logic [IDX_W-1:0]         s_col;
  logic signed [PROB_W-1:0] s_prob;
  logic [DRAW_W-1:0]        s_draw;
  logic [TW-1:0]            s_tgt_w;

  assign s_cmd   = s_axis_tuser[0];
  assign s_row   = s_axis_tdata[3:0];
  assign s_col   = s_axis_tdata[7:4];
  assign s_prob  = s_axis_tdata[25:8];
  assign s_draw  = s_axis_tdata[41:26];
  assign s_tgt_w = (TW'(s_draw) << SH_L) >> SH_R;

  // State
  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        clr_q;
  logic [IDX_W-1:0]     row_q, col_q;
  logic [PROB_W-2:0]    val_q;
  logic [SW-1:0]        tgt_q, sum_q, sum_nx;
  status_e              pre_q, res_stat_q, res_stat_d;
  logic [CW-1:0]        walk_q;
  logic [IDX_W-1:0]     res_rate_q, res_rate_d;
  logic                 res_ld;
  logic                 m_valid_q;
  logic [7:0]           m_data_q;

  // Table RAM: {defined, value}
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rd_word_q, wr_word;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          rd_en, wr_en;

  logic          accept, out_free;
  logic          row_bad, col_bad, val_bad;
  logic          rd_def, hit, last_col, walk_stop;
  logic [VW-1:0] rd_val;
  logic [IDX_W-1:0] last_rate;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // Configuration: clamp the rating count into 1..MAX_RATINGS
  always_comb begin
    if (cfg_wr_data_i == '0) begin
      cnt_d = CW'(1);
    end else if (int'(cfg_wr_data_i) > MAX_RATINGS) begin
      cnt_d = CW'(MAX_RATINGS);
    end else begin
      cnt_d = CW'(cfg_wr_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CW'(RST_CNT);
    end else if (cfg_wr_en_i) begin
      cnt_q <= cnt_d;
    end
  end

  // Checks on the incoming word
  assign row_bad = XW'(s_row) >= XW'(cnt_q);
  assign col_bad = XW'(s_col) >= XW'(cnt_q);
  assign val_bad = s_prob[PROB_W-1] || (VCW'(s_prob[PROB_W-2:0]) > ONE_VAL);

  // Walk step on the word read last cycle
  assign rd_def    = rd_word_q[VW];
  assign rd_val    = rd_word_q[VW-1:0];
  assign sum_nx    = sum_q + SW'(rd_val);
  assign hit       = tgt_q < sum_nx;
  assign last_col  = walk_q == (cnt_q - CW'(1));
  assign walk_stop = !rd_def || hit || last_col;
  assign last_rate = IDX_W'(cnt_q - CW'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (s_cmd == CMD_WRITE) state_d = ST_WRCHK;
          else if (row_bad)       state_d = ST_RESP;
          else                    state_d = ST_WALK;
        end
      end
      ST_WRCHK: state_d = ST_RESP;
      ST_WALK: begin
        if (walk_stop) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the controller: RAM ports and result capture
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = ent_addr(s_row, 0);
    wr_en         = 1'b0;
    wr_addr       = ent_addr(row_q, int'(col_q));
    wr_word       = {1'b1, VW'(val_q)};
    res_ld        = 1'b0;
    res_rate_d    = '0;
    res_stat_d    = STAT_OK;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_word = '0;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        rd_en   = accept;
        rd_addr = ent_addr(s_row, (s_cmd == CMD_WRITE) ? int'(s_col) : 0);
        if (accept && s_cmd == CMD_SAMPLE && row_bad) begin
          res_ld     = 1'b1;
          res_stat_d = STAT_INDEX;
        end
      end
      ST_WRCHK: begin
        res_ld = 1'b1;
        if (pre_q != STAT_OK) begin
          res_stat_d = pre_q;
        end else if (rd_def) begin
          res_stat_d = STAT_REDEF;
        end else begin
          wr_en = 1'b1;
        end
      end
      ST_WALK: begin
        // the next column is fetched while this one is checked
        rd_en   = !walk_stop;
        rd_addr = ent_addr(row_q, int'(walk_q) + 1);
        if (walk_stop) begin
          res_ld     = 1'b1;
          res_rate_d = (rd_def && hit) ? IDX_W'(walk_q) : last_rate;
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  // Table RAM, one write and one registered read port; a write back in
  // ST_WRCHK is never followed by a read before ST_RESP is left
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_word;
    if (rd_en) rd_word_q <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == ST_RESP && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Item and walk registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q  <= s_row;
      col_q  <= s_col;
      val_q  <= s_prob[PROB_W-2:0];
      tgt_q  <= SW'(s_tgt_w);
      walk_q <= '0;
      sum_q  <= '0;
      if (col_bad || row_bad) pre_q <= STAT_INDEX;
      else if (val_bad)       pre_q <= STAT_RANGE;
      else                    pre_q <= STAT_OK;
    end else if (state_q == ST_WALK && !walk_stop) begin
      walk_q <= walk_q + CW'(1);
      sum_q  <= sum_nx;
    end
    if (res_ld) begin
      res_rate_q <= res_rate_d;
      res_stat_q <= res_stat_d;
    end
    if (state_q == ST_RESP && out_free) begin
      m_data_q <= {2'b00, res_stat_q, res_rate_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The walk never runs past the last column in use
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> walk_q < cnt_q)
    else $error("walk column beyond rating count");

  // A table write during normal operation never overwrites a defined entry
  a_no_redef: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && state_q != ST_CLEAR) |-> !rd_def)
    else $error("defined entry overwritten");

  // A new result only appears out of the result state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == ST_RESP)
    else $error("output loaded outside result state");

  // Every rejected word reports rating zero
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[5:4] != STAT_OK) |-> m_data_q[3:0] == '0)
    else $error("rejected word with nonzero rating");

endmodule
